// File: hdl/gcvs_pkg.sv
package gcvs_pkg;

  localparam int FRAC_BITS    = 30;
  localparam int CORDIC_STEPS = 32;
  localparam int TSHIFT       = 30 - FRAC_BITS;

  localparam int VW   = 32;  // vector component width on the ports
  localparam int OPW  = 34;  // internal operand width
  localparam int ACCW = 68;  // product and accumulator width
  localparam int DVW  = 62;  // divider dividend and quotient width
  localparam int DSW  = 33;  // divider divisor width
  localparam int CNTW = 6;
  localparam int RESW = 16;
  localparam int RADW = 17;
  localparam int CFG_IW = 1;

  localparam int CORD_N = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
  localparam int SQ_N   = 32;

  localparam logic [RESW-1:0] RES_RESET = 16'd500;
  localparam logic [RADW-1:0] RAD_RESET = 17'd6371;

  localparam logic [CFG_IW-1:0] CFG_RESOLUTION = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_RADIUS     = 1'b1;

  localparam longint ONE_L = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [OPW-1:0] ONE_Q   = OPW'(ONE_L);
  localparam logic signed [OPW-1:0] GAIN_Q  = OPW'(64'sd652032874 >>> TSHIFT);
  localparam logic signed [OPW-1:0] HALF_Q  = OPW'(64'sd1686629713 >>> TSHIFT);
  localparam logic [DVW-1:0]        PI_Q    = DVW'(64'd3373259426 >> TSHIFT);
  localparam logic signed [ACCW-1:0] DOT_MIN = -(ACCW'(1) << (2 * FRAC_BITS));
  localparam logic [ACCW-1:0]       RND_HALF = ACCW'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic           start;
    logic [DVW-1:0] dividend;
    logic [DSW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [DVW-1:0] quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    SRC_P0, SRC_P1, SRC_P2, SRC_C0, SRC_C1, SRC_C2, SRC_A0, SRC_A1, SRC_A2,
    SRC_K0, SRC_K1, SRC_K2, SRC_KP0, SRC_KP1, SRC_KP2, SRC_KDP,
    SRC_T0, SRC_T1, SRC_T2, SRC_CL, SRC_SL, SRC_OMC
  } src_t;

  typedef enum logic [4:0] {
    DST_NONE, DST_DOT, DST_A0, DST_A1, DST_A2, DST_M2, DST_KP0, DST_KP1, DST_KP2,
    DST_KDP, DST_T0, DST_T1, DST_T2, DST_V0, DST_V1, DST_V2
  } dst_t;

  typedef struct packed {
    src_t a;
    src_t b;
    logic neg;
    dst_t dst;
  } op_t;

  localparam logic [CNTW-1:0] OP_KP_START = 6'd12;

  // Multiply-accumulate program: dot test, axis, axis length, then Rodrigues.
  function automatic op_t op_decode(input logic [CNTW-1:0] idx);
    op_t o;
    o = '{a: SRC_P0, b: SRC_C0, neg: 1'b0, dst: DST_NONE};
    case (idx)
      6'd0:  o = '{SRC_P0, SRC_C0, 1'b0, DST_NONE};
      6'd1:  o = '{SRC_P1, SRC_C1, 1'b0, DST_NONE};
      6'd2:  o = '{SRC_P2, SRC_C2, 1'b0, DST_DOT};
      6'd3:  o = '{SRC_P1, SRC_C2, 1'b0, DST_NONE};
      6'd4:  o = '{SRC_P2, SRC_C1, 1'b1, DST_A0};
      6'd5:  o = '{SRC_P2, SRC_C0, 1'b0, DST_NONE};
      6'd6:  o = '{SRC_P0, SRC_C2, 1'b1, DST_A1};
      6'd7:  o = '{SRC_P0, SRC_C1, 1'b0, DST_NONE};
      6'd8:  o = '{SRC_P1, SRC_C0, 1'b1, DST_A2};
      6'd9:  o = '{SRC_A0, SRC_A0, 1'b0, DST_NONE};
      6'd10: o = '{SRC_A1, SRC_A1, 1'b0, DST_NONE};
      6'd11: o = '{SRC_A2, SRC_A2, 1'b0, DST_M2};
      6'd12: o = '{SRC_K1, SRC_P2, 1'b0, DST_NONE};
      6'd13: o = '{SRC_K2, SRC_P1, 1'b1, DST_KP0};
      6'd14: o = '{SRC_K2, SRC_P0, 1'b0, DST_NONE};
      6'd15: o = '{SRC_K0, SRC_P2, 1'b1, DST_KP1};
      6'd16: o = '{SRC_K0, SRC_P1, 1'b0, DST_NONE};
      6'd17: o = '{SRC_K1, SRC_P0, 1'b1, DST_KP2};
      6'd18: o = '{SRC_K0, SRC_P0, 1'b0, DST_NONE};
      6'd19: o = '{SRC_K1, SRC_P1, 1'b0, DST_NONE};
      6'd20: o = '{SRC_K2, SRC_P2, 1'b0, DST_KDP};
      6'd21: o = '{SRC_K0, SRC_KDP, 1'b0, DST_T0};
      6'd22: o = '{SRC_K1, SRC_KDP, 1'b0, DST_T1};
      6'd23: o = '{SRC_K2, SRC_KDP, 1'b0, DST_T2};
      6'd24: o = '{SRC_P0, SRC_CL, 1'b0, DST_NONE};
      6'd25: o = '{SRC_KP0, SRC_SL, 1'b0, DST_NONE};
      6'd26: o = '{SRC_T0, SRC_OMC, 1'b0, DST_V0};
      6'd27: o = '{SRC_P1, SRC_CL, 1'b0, DST_NONE};
      6'd28: o = '{SRC_KP1, SRC_SL, 1'b0, DST_NONE};
      6'd29: o = '{SRC_T1, SRC_OMC, 1'b0, DST_V1};
      6'd30: o = '{SRC_P2, SRC_CL, 1'b0, DST_NONE};
      6'd31: o = '{SRC_KP2, SRC_SL, 1'b0, DST_NONE};
      6'd32: o = '{SRC_T2, SRC_OMC, 1'b0, DST_V2};
      default: o = '{SRC_P0, SRC_C0, 1'b0, DST_NONE};
    endcase
    return o;
  endfunction

  function automatic logic signed [OPW-1:0] atan_q(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0:  t = 32'h3243F6A8;
      5'd1:  t = 32'h1DAC6705;
      5'd2:  t = 32'h0FADBAFC;
      5'd3:  t = 32'h07F56EA6;
      5'd4:  t = 32'h03FEAB76;
      5'd5:  t = 32'h01FFD55B;
      5'd6:  t = 32'h00FFFAAA;
      5'd7:  t = 32'h007FFF55;
      5'd8:  t = 32'h003FFFEA;
      5'd9:  t = 32'h001FFFFD;
      5'd10: t = 32'h000FFFFF;
      5'd11: t = 32'h0007FFFF;
      5'd12: t = 32'h0003FFFF;
      5'd13: t = 32'h0001FFFF;
      5'd14: t = 32'h0000FFFF;
      5'd15: t = 32'h00007FFF;
      5'd16: t = 32'h00003FFF;
      5'd17: t = 32'h00001FFF;
      5'd18: t = 32'h00000FFF;
      5'd19: t = 32'h000007FF;
      5'd20: t = 32'h000003FF;
      5'd21: t = 32'h000001FF;
      5'd22: t = 32'h000000FF;
      5'd23: t = 32'h0000007F;
      5'd24: t = 32'h0000003F;
      5'd25: t = 32'h0000001F;
      5'd26: t = 32'h0000000F;
      5'd27: t = 32'h00000008;
      5'd28: t = 32'h00000004;
      5'd29: t = 32'h00000002;
      5'd30: t = 32'h00000001;
      5'd31: t = 32'h00000000;
      default: t = 32'h00000000;
    endcase
    return OPW'(t >> TSHIFT);
  endfunction

  function automatic logic signed [OPW-1:0] sat_in(input logic signed [VW-1:0] v);
    logic signed [OPW-1:0] w;
    w = OPW'(v);
    if (w > ONE_Q) return ONE_Q;
    if (w < -ONE_Q) return -ONE_Q;
    return w;
  endfunction

  function automatic logic signed [OPW-1:0] sat_acc(input logic signed [ACCW-1:0] v);
    if (v > ACCW'(ONE_Q)) return ONE_Q;
    if (v < -ACCW'(ONE_Q)) return -ONE_Q;
    return OPW'(v);
  endfunction

  // Scale down by one unit, rounding to nearest with ties away from zero.
  function automatic logic signed [ACCW-1:0] rnd_q(input logic signed [ACCW-1:0] v);
    logic [ACCW-1:0] m;
    logic [ACCW-1:0] r;
    m = v[ACCW-1] ? ACCW'(-v) : ACCW'(v);
    r = (m + RND_HALF) >> FRAC_BITS;
    return v[ACCW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [DVW-1:0] norm_num(input logic signed [OPW-1:0] a,
                                              input logic [VW-1:0] len);
    logic [VW-1:0] m;
    m = a[OPW-1] ? VW'(-a) : VW'(a);
    return (DVW'(m) << FRAC_BITS) + DVW'(len >> 1);
  endfunction

endpackage

// File: hdl/gcvs_ifs.sv
interface gcvs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] click_x;
  logic signed [31:0] click_y;
  logic signed [31:0] click_z;
  logic               clamp_request;
  logic               new_geometry;

  modport source(output valid, click_x, click_y, click_z, clamp_request, new_geometry,
                 input ready);
  modport sink(input valid, click_x, click_y, click_z, clamp_request, new_geometry,
               output ready);
endinterface

interface gcvs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;
  logic               was_clamped;

  modport source(output valid, vertex_x, vertex_y, vertex_z, was_clamped, input ready);
  modport sink(input valid, vertex_x, vertex_y, vertex_z, was_clamped, output ready);
endinterface

// File: hdl/gcvs_div.sv
module gcvs_div
  import gcvs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [DVW-1:0]  nq_r;
  logic [DSW-1:0]  den_r;
  logic [DSW-1:0]  rem_r;
  logic [DSW:0]    rem_sh;
  logic            take;

  // Restoring division: the dividend shifts out at the top while quotient
  // bits shift in at the bottom of the same register.
  assign rem_sh = {rem_r, nq_r[DVW-1]};
  assign take   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        nq_r   <= req.dividend;
        den_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= take ? DSW'(rem_sh - {1'b0, den_r}) : DSW'(rem_sh);
        nq_r  <= {nq_r[DVW-2:0], take};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(DVW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = nq_r;

endmodule

// File: hdl/great_circle_vertex_step_clamp.sv
// Places clicked unit vectors (Q1.30) as vertices. A clamping click with a previous
// vertex whose arc exceeds resolution/radius yields the previous vertex rotated toward
// the click by exactly that limit. A plain click, or one that cannot clamp, goes to the
// done state straight after acceptance. A clamping click runs the limit division
// (and stops there when the limit is pi or more), a CORDIC of up to 32 steps and the
// dot test; when it clamps, it adds a square root, three divisions and the
// multiply-accumulate program on one 34x34 multiplier. One divider serves all of
// these divisions and one multiplier the whole program; a stalled result holds the
// block in its last state until the output register is free. The block takes one
// transaction at a time; a finished result waits in the output register while the
// next transaction is accepted.
module great_circle_vertex_step_clamp
  import gcvs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  gcvs_in_if.sink           in_ch,
  gcvs_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [RADW-1:0]   cfg_data
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DIV  = 8'b0000_0010,
    ST_CORD = 8'b0000_0100,
    ST_MUL  = 8'b0000_1000,
    ST_ACC  = 8'b0001_0000,
    ST_WB   = 8'b0010_0000,
    ST_SQRT = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  state_t state_r;

  logic [RESW-1:0] res_r;
  logic [RADW-1:0] rad_r;
  logic            has_r;
  logic signed [VW-1:0] last_x_r, last_y_r, last_z_r;
  logic signed [VW-1:0] vtx_x_r, vtx_y_r, vtx_z_r;
  logic            vclamp_r;

  logic signed [OPW-1:0] p0_r, p1_r, p2_r, c0_r, c1_r, c2_r;
  logic signed [OPW-1:0] a0_r, a1_r, a2_r, k0_r, k1_r, k2_r;
  logic signed [OPW-1:0] kp0_r, kp1_r, kp2_r, kdp_r, t0_r, t1_r, t2_r;
  logic signed [OPW-1:0] cl_r, sl_r, omc_r;
  logic signed [OPW-1:0] x_r, y_r, z_r;
  logic            lim_hi_r;
  logic            div_lim_r;
  logic [1:0]      j_r;
  logic [CNTW-1:0] cnt_r;
  logic [CNTW-1:0] op_r;
  logic signed [ACCW-1:0] prod_r, acc_r, acc_nxt, rnd_v;
  logic [63:0]     sq_r;
  logic [VW-1:0]   root_r;
  logic [VW+3:0]   rem_r, rem_nxt, trial;

  logic            out_valid_r;
  logic signed [VW-1:0] out_x_r, out_y_r, out_z_r;
  logic            out_clamp_r;

  op_t             op;
  logic signed [OPW-1:0] op_a, op_b, a_next;
  logic            in_acc, go;
  logic signed [OPW-1:0] cs, ss, dx, dy, at;
  logic signed [OPW-1:0] zq;
  logic            dot_ok;
  div_req_t        div_req;
  div_rsp_t        div_rsp;

  gcvs_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign go = in_ch.clamp_request && has_r && !in_ch.new_geometry &&
              (res_r != '0) && (rad_r != '0);

  assign op = op_decode(op_r);

  function automatic logic signed [OPW-1:0] pick(input src_t s,
    input logic signed [OPW-1:0] p0, p1, p2, c0, c1, c2, a0, a1, a2, k0, k1, k2,
    input logic signed [OPW-1:0] kp0, kp1, kp2, kdp, t0, t1, t2, cl, sl, omc);
    logic signed [OPW-1:0] v;
    case (s)
      SRC_P0:  v = p0;
      SRC_P1:  v = p1;
      SRC_P2:  v = p2;
      SRC_C0:  v = c0;
      SRC_C1:  v = c1;
      SRC_C2:  v = c2;
      SRC_A0:  v = a0;
      SRC_A1:  v = a1;
      SRC_A2:  v = a2;
      SRC_K0:  v = k0;
      SRC_K1:  v = k1;
      SRC_K2:  v = k2;
      SRC_KP0: v = kp0;
      SRC_KP1: v = kp1;
      SRC_KP2: v = kp2;
      SRC_KDP: v = kdp;
      SRC_T0:  v = t0;
      SRC_T1:  v = t1;
      SRC_T2:  v = t2;
      SRC_CL:  v = cl;
      SRC_SL:  v = sl;
      SRC_OMC: v = omc;
      default: v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    op_a = pick(op.a, p0_r, p1_r, p2_r, c0_r, c1_r, c2_r, a0_r, a1_r, a2_r, k0_r, k1_r,
                k2_r, kp0_r, kp1_r, kp2_r, kdp_r, t0_r, t1_r, t2_r, cl_r, sl_r, omc_r);
    op_b = pick(op.b, p0_r, p1_r, p2_r, c0_r, c1_r, c2_r, a0_r, a1_r, a2_r, k0_r, k1_r,
                k2_r, kp0_r, kp1_r, kp2_r, kdp_r, t0_r, t1_r, t2_r, cl_r, sl_r, omc_r);
  end

  assign acc_nxt = op.neg ? acc_r - prod_r : acc_r + prod_r;
  assign rnd_v   = rnd_q(acc_r);
  assign dot_ok  = (acc_r >= DOT_MIN) && (acc_r < (ACCW'(cl_r) <<< FRAC_BITS));

  // CORDIC step and end-of-rotation saturation.
  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;
  assign at = atan_q(cnt_r[4:0]);
  assign cs = sat_acc(ACCW'(x_r));
  assign ss = sat_acc(ACCW'(y_r));
  assign zq = OPW'(div_rsp.quot);

  // One square-root digit per cycle.
  assign rem_nxt = {rem_r[VW+1:0], sq_r[63:62]};
  assign trial   = {2'b00, root_r, 2'b01};

  always_comb begin
    case (j_r)
      2'd0:    a_next = a1_r;
      2'd1:    a_next = a2_r;
      default: a_next = a2_r;
    endcase
  end

  always_comb begin
    div_req = '0;
    if (state_r == ST_IDLE && in_acc && go) begin
      div_req.start    = 1'b1;
      div_req.dividend = DVW'(res_r) << FRAC_BITS;
      div_req.divisor  = DSW'(rad_r);
    end else if (state_r == ST_SQRT && cnt_r == CNTW'(SQ_N)) begin
      div_req.start    = 1'b1;
      div_req.dividend = norm_num(a0_r, root_r);
      div_req.divisor  = DSW'(root_r);
    end else if (state_r == ST_DIV && div_rsp.done && !div_lim_r && j_r != 2'd2) begin
      div_req.start    = 1'b1;
      div_req.dividend = norm_num(a_next, root_r);
      div_req.divisor  = DSW'(root_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_r       <= RES_RESET;
      rad_r       <= RAD_RESET;
      has_r       <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_z_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RESOLUTION: res_r <= cfg_data[RESW-1:0];
          CFG_RADIUS:     rad_r <= cfg_data;
          default:        ;
        endcase
      end
      if (out_ch.ready && state_r != ST_DONE) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            vtx_x_r  <= in_ch.click_x;
            vtx_y_r  <= in_ch.click_y;
            vtx_z_r  <= in_ch.click_z;
            vclamp_r <= 1'b0;
            p0_r <= sat_in(last_x_r);
            p1_r <= sat_in(last_y_r);
            p2_r <= sat_in(last_z_r);
            c0_r <= sat_in(in_ch.click_x);
            c1_r <= sat_in(in_ch.click_y);
            c2_r <= sat_in(in_ch.click_z);
            div_lim_r <= 1'b1;
            state_r   <= go ? ST_DIV : ST_DONE;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            if (div_lim_r) begin
              // A limit of pi or more never clamps.
              if (div_rsp.quot >= PI_Q) begin
                state_r <= ST_DONE;
              end else begin
                lim_hi_r <= zq > HALF_Q;
                z_r      <= (zq > HALF_Q) ? zq - HALF_Q : zq;
                x_r      <= GAIN_Q;
                y_r      <= '0;
                cnt_r    <= '0;
                state_r  <= ST_CORD;
              end
            end else begin
              case (j_r)
                2'd0:    k0_r <= a0_r[OPW-1] ? -zq : zq;
                2'd1:    k1_r <= a1_r[OPW-1] ? -zq : zq;
                default: k2_r <= a2_r[OPW-1] ? -zq : zq;
              endcase
              j_r <= j_r + 1'b1;
              if (j_r == 2'd2) begin
                op_r    <= OP_KP_START;
                state_r <= ST_MUL;
              end
            end
          end
        end
        ST_CORD: begin
          if (cnt_r == CNTW'(CORD_N)) begin
            // Above pi/2 the angle was reduced, so cos = -sin' and sin = cos'.
            cl_r    <= lim_hi_r ? -ss : cs;
            sl_r    <= lim_hi_r ? cs : ss;
            op_r    <= '0;
            acc_r   <= '0;
            state_r <= ST_MUL;
          end else begin
            if (!z_r[OPW-1]) begin
              x_r <= x_r - dx;
              y_r <= y_r + dy;
              z_r <= z_r - at;
            end else begin
              x_r <= x_r + dx;
              y_r <= y_r - dy;
              z_r <= z_r + at;
            end
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_MUL: begin
          prod_r  <= op_a * op_b;
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          acc_r <= acc_nxt;
          if (op.dst == DST_NONE) begin
            op_r    <= op_r + 1'b1;
            state_r <= ST_MUL;
          end else begin
            state_r <= ST_WB;
          end
        end
        ST_WB: begin
          acc_r   <= '0;
          op_r    <= op_r + 1'b1;
          state_r <= ST_MUL;
          case (op.dst)
            DST_DOT: begin
              omc_r <= ONE_Q - cl_r;
              if (!dot_ok) state_r <= ST_DONE;
            end
            DST_A0:  a0_r  <= OPW'(rnd_v);
            DST_A1:  a1_r  <= OPW'(rnd_v);
            DST_A2:  a2_r  <= OPW'(rnd_v);
            DST_M2: begin
              if (acc_r[63:0] == '0) begin
                // Coincident or antipodal: no rotation axis.
                state_r <= ST_DONE;
              end else begin
                sq_r    <= acc_r[63:0];
                root_r  <= '0;
                rem_r   <= '0;
                cnt_r   <= '0;
                state_r <= ST_SQRT;
              end
            end
            DST_KP0: kp0_r <= OPW'(rnd_v);
            DST_KP1: kp1_r <= OPW'(rnd_v);
            DST_KP2: kp2_r <= OPW'(rnd_v);
            DST_KDP: kdp_r <= OPW'(rnd_v);
            DST_T0:  t0_r  <= OPW'(rnd_v);
            DST_T1:  t1_r  <= OPW'(rnd_v);
            DST_T2:  t2_r  <= OPW'(rnd_v);
            DST_V0:  vtx_x_r <= VW'(sat_acc(rnd_v));
            DST_V1:  vtx_y_r <= VW'(sat_acc(rnd_v));
            DST_V2: begin
              vtx_z_r  <= VW'(sat_acc(rnd_v));
              vclamp_r <= 1'b1;
              state_r  <= ST_DONE;
            end
            default: ;
          endcase
        end
        ST_SQRT: begin
          if (cnt_r == CNTW'(SQ_N)) begin
            div_lim_r <= 1'b0;
            j_r       <= 2'd0;
            state_r   <= ST_DIV;
          end else begin
            if (rem_nxt >= trial) begin
              rem_r  <= rem_nxt - trial;
              root_r <= {root_r[VW-2:0], 1'b1};
            end else begin
              rem_r  <= rem_nxt;
              root_r <= {root_r[VW-2:0], 1'b0};
            end
            sq_r  <= {sq_r[61:0], 2'b00};
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_x_r     <= vtx_x_r;
            out_y_r     <= vtx_y_r;
            out_z_r     <= vtx_z_r;
            out_clamp_r <= vclamp_r;
            last_x_r    <= vtx_x_r;
            last_y_r    <= vtx_y_r;
            last_z_r    <= vtx_z_r;
            has_r       <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.vertex_x    = out_x_r;
  assign out_ch.vertex_y    = out_y_r;
  assign out_ch.vertex_z    = out_z_r;
  assign out_ch.was_clamped = out_clamp_r;

endmodule

// File: hdl/gcvs_checker.sv
module gcvs_checker
  import gcvs_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [VW-1:0] vertex_x,
  input logic signed [VW-1:0] vertex_y,
  input logic signed [VW-1:0] vertex_z,
  input logic                 was_clamped
);

  // One transaction at a time: the block is busy right after accepting.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction was in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(vertex_x) && $stable(vertex_y) &&
    $stable(vertex_z) && $stable(was_clamped))
    else $error("stalled result changed");

  // A rotated vertex is always saturated to the unit range.
  a_clamped_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && was_clamped |->
      vertex_x <= VW'(ONE_Q) && vertex_x >= -VW'(ONE_Q) &&
      vertex_y <= VW'(ONE_Q) && vertex_y >= -VW'(ONE_Q) &&
      vertex_z <= VW'(ONE_Q) && vertex_z >= -VW'(ONE_Q))
    else $error("clamped vertex outside unit range");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind great_circle_vertex_step_clamp gcvs_checker u_gcvs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .vertex_x   (out_ch.vertex_x),
  .vertex_y   (out_ch.vertex_y),
  .vertex_z   (out_ch.vertex_z),
  .was_clamped(out_ch.was_clamped)
);
